[hw/rtl/tle_pkg.sv]
// Shared types and constants of the terminal line editor.
// Used by tle_cell, tle_cell_row and terminal_line_editor_core; no dependencies.
package tle_pkg;

    localparam int LINE_CAPACITY = 16;
    localparam int IDX_W         = $clog2(LINE_CAPACITY);
    localparam int BYTE_W        = 8;

    // longest line held: one slot is kept free
    localparam logic [IDX_W-1:0] LEN_MAX = IDX_W'(LINE_CAPACITY - 1);

    localparam logic [BYTE_W-1:0] CH_BS       = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_C        = 8'h43;
    localparam logic [BYTE_W-1:0] CH_D        = 8'h44;
    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_DEL      = 8'h7F;
    localparam logic [BYTE_W-1:0] ENTER_RESET = CH_CR;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_TAIL,
        ST_POST,
        ST_REP
    } t_state;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_SEEN,
        ESC_BRACKET
    } t_esc;

    typedef enum logic [1:0] {
        OP_PLAIN,
        OP_BACKSPACE,
        OP_ENTER
    } t_op;

    typedef enum logic [1:0] {
        UNIT_LEFT,
        UNIT_RIGHT,
        UNIT_BS
    } t_unit;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [IDX_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
    } t_cell_cmd;

endpackage

[hw/rtl/terminal_line_editor_core.sv]
// Top level of the terminal line editor: escape decode, cursor/length
// bookkeeping and the echo/line sequencer. Depends on tle_pkg and tle_cell_row.
//
//  channel  direction  handshake                 word
//  ------   ---------  ------------------------  -------------------------------------
//  rx       in         i_valid / o_stall         i_rx_byte
//  result   out        o_valid / i_stall         o_out_byte o_to_line o_line_done o_last
//  cfg      in         i_cfg_valid / o_cfg_ready i_cfg_data (enter code)
//
// A received word is taken only while the sequencer is idle; the cells shift
// at the edge that takes it. The sequencer then issues one result word per
// cycle while the output register is free or being drained, and the block
// takes no new word until the last result of the word is issued.
// o_stall is high while the sequencer runs. A stalled output only freezes
// the sequencer. Reset (synchronous, low) clears length, cursor, escape
// phase, sequencer and sets the enter code to CR; the line store is not
// cleared. o_cfg_ready is always high.
module terminal_line_editor_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [tle_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [tle_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_to_line,
    output logic                       o_line_done,
    output logic                       o_last,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tle_pkg::BYTE_W-1:0] i_cfg_data
);
    import tle_pkg::*;

    // ---- architectural state
    t_esc              r_esc;
    logic [IDX_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_cur;
    logic [BYTE_W-1:0] r_enter;

    // ---- sequencer
    t_state            r_state,  n_state;
    t_op               r_op,     n_op;
    t_unit             r_unit,   n_unit;
    logic [IDX_W-1:0]  r_idx,    n_idx;    // next store slot to send
    logic [IDX_W-1:0]  r_end,    n_end;    // one past the last slot to send
    logic [IDX_W-1:0]  r_rep,    n_rep;    // cursor codes still to send
    logic [1:0]        r_sub,    n_sub;    // byte within a prefix or code

    // ---- output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_to_line;
    logic              r_out_done;
    logic              r_out_last;

    // ---- decode of the incoming word
    t_esc              d_esc;
    t_op               d_op;
    t_unit             d_unit;
    t_state            d_start;
    logic [IDX_W-1:0]  d_len, d_cur, d_idx, d_end, d_rep;
    t_cell_cmd         d_cmd;
    t_cell_cmd         w_cmd;

    logic              w_accept;
    logic              w_step;
    logic [BYTE_W-1:0] w_rd_data;

    // sequence helpers
    logic              w_tail_any;
    logic              w_tail_more;
    logic              w_has_post;
    logic              w_rep_any;
    logic              w_pre_end;
    logic              w_unit_end;

    // emitted word
    logic [BYTE_W-1:0] e_byte;
    logic              e_to_line;
    logic              e_done;
    logic              e_last;

    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && !o_stall;
    // one result per cycle whenever the output register can take it
    assign w_step      = (r_state != ST_IDLE) && (!r_out_valid || !i_stall);

    // ------------------------------------------------------------------
    // Decode: escape sequences first, then backspace, enter, plain insert.
    // ------------------------------------------------------------------
    always_comb begin
        d_esc    = ESC_NONE;
        d_op     = OP_PLAIN;
        d_unit   = UNIT_LEFT;
        d_start  = ST_IDLE;
        d_len    = r_len;
        d_cur    = r_cur;
        d_idx    = '0;
        d_end    = '0;
        d_rep    = '0;
        d_cmd.op   = CELL_HOLD;
        d_cmd.pos  = r_cur;
        d_cmd.data = i_rx_byte;
        case (r_esc)
            ESC_SEEN: begin
                d_esc = (i_rx_byte == CH_LBRACKET) ? ESC_BRACKET : ESC_NONE;
            end
            ESC_BRACKET: begin
                if (i_rx_byte == CH_D && r_cur != '0) begin
                    d_cur   = r_cur - 1'b1;
                    d_unit  = UNIT_LEFT;
                    d_rep   = IDX_W'(1);
                    d_start = ST_REP;
                end else if (i_rx_byte == CH_C && r_cur < r_len) begin
                    d_cur   = r_cur + 1'b1;
                    d_unit  = UNIT_RIGHT;
                    d_rep   = IDX_W'(1);
                    d_start = ST_REP;
                end
            end
            default: begin
                if (i_rx_byte == CH_ESC) begin
                    d_esc = ESC_SEEN;
                end else if (i_rx_byte == CH_BS || i_rx_byte == CH_DEL) begin
                    if (r_cur != '0) begin
                        // BS, new tail, space, then tail + 1 BS back
                        d_cmd.op  = CELL_DELETE;
                        d_cmd.pos = r_cur - 1'b1;
                        d_len     = r_len - 1'b1;
                        d_cur     = r_cur - 1'b1;
                        d_op      = OP_BACKSPACE;
                        d_unit    = UNIT_BS;
                        d_idx     = r_cur - 1'b1;
                        d_end     = r_len - 1'b1;
                        d_rep     = r_len - r_cur + 1'b1;
                        d_start   = ST_PRE;
                    end
                end else if (i_rx_byte == r_enter) begin
                    // CR LF then the whole line; store contents stay put
                    d_op    = OP_ENTER;
                    d_idx   = '0;
                    d_end   = r_len;
                    d_len   = '0;
                    d_cur   = '0;
                    d_start = ST_PRE;
                end else if (r_len != LEN_MAX) begin
                    // echo from the new byte to the end, then step back
                    d_cmd.op = CELL_INSERT;
                    d_len    = r_len + 1'b1;
                    d_cur    = r_cur + 1'b1;
                    d_idx    = r_cur;
                    d_end    = r_len + 1'b1;
                    d_unit   = UNIT_LEFT;
                    d_rep    = r_len - r_cur;
                    d_start  = ST_TAIL;
                end
            end
        endcase
    end

    always_comb begin
        w_cmd    = d_cmd;
        w_cmd.op = w_accept ? d_cmd.op : CELL_HOLD;
    end

    tle_cell_row u_row (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_rd_idx  (r_idx),
        .o_rd_data (w_rd_data)
    );

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------
    assign w_tail_any  = (r_idx != r_end);
    assign w_tail_more = (r_idx != r_end - 1'b1);
    assign w_has_post  = (r_op == OP_BACKSPACE);
    assign w_rep_any   = (r_rep != '0);
    assign w_pre_end   = (r_op != OP_ENTER) || (r_sub == 2'd1);
    assign w_unit_end  = (r_unit == UNIT_BS) || (r_sub == 2'd2);

    // ------------------------------------------------------------------
    // Result word of the current sequencer position
    // ------------------------------------------------------------------
    always_comb begin
        e_byte    = CH_SPACE;
        e_to_line = 1'b0;
        e_done    = 1'b0;
        e_last    = 1'b0;
        case (r_state)
            ST_PRE: begin
                if (r_op == OP_ENTER) begin
                    e_byte = (r_sub == 2'd0) ? CH_CR : CH_LF;
                    e_done = (r_sub == 2'd1) && !w_tail_any;
                end else begin
                    e_byte = CH_BS;
                end
                e_last = w_pre_end && !w_tail_any && !w_has_post && !w_rep_any;
            end
            ST_TAIL: begin
                e_byte    = w_rd_data;
                e_to_line = (r_op == OP_ENTER);
                e_done    = (r_op == OP_ENTER) && !w_tail_more;
                e_last    = !w_tail_more && !w_has_post && !w_rep_any;
            end
            ST_POST: begin
                e_byte = CH_SPACE;
                e_last = !w_rep_any;
            end
            ST_REP: begin
                if (r_unit == UNIT_BS) begin
                    e_byte = CH_BS;
                end else begin
                    case (r_sub)
                        2'd0:    e_byte = CH_ESC;
                        2'd1:    e_byte = CH_LBRACKET;
                        default: e_byte = (r_unit == UNIT_RIGHT) ? CH_C : CH_D;
                    endcase
                end
                e_last = w_unit_end && (r_rep == IDX_W'(1));
            end
            default: begin
                e_byte = CH_SPACE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_unit  = r_unit;
        n_idx   = r_idx;
        n_end   = r_end;
        n_rep   = r_rep;
        n_sub   = r_sub;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = d_start;
                    n_op    = d_op;
                    n_unit  = d_unit;
                    n_idx   = d_idx;
                    n_end   = d_end;
                    n_rep   = d_rep;
                    n_sub   = 2'd0;
                end
            end
            ST_PRE: begin
                if (w_step) begin
                    if (w_pre_end) begin
                        n_sub = 2'd0;
                        if (w_tail_any) begin
                            n_state = ST_TAIL;
                        end else if (w_has_post) begin
                            n_state = ST_POST;
                        end else if (w_rep_any) begin
                            n_state = ST_REP;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
            end
            ST_TAIL: begin
                if (w_step) begin
                    n_idx = r_idx + 1'b1;
                    if (!w_tail_more) begin
                        if (w_has_post) begin
                            n_state = ST_POST;
                        end else if (w_rep_any) begin
                            n_state = ST_REP;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_POST: begin
                if (w_step) begin
                    n_state = w_rep_any ? ST_REP : ST_IDLE;
                end
            end
            ST_REP: begin
                if (w_step) begin
                    if (w_unit_end) begin
                        n_sub = 2'd0;
                        n_rep = r_rep - 1'b1;
                        if (r_rep == IDX_W'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_PLAIN;
            r_unit      <= UNIT_LEFT;
            r_idx       <= '0;
            r_end       <= '0;
            r_rep       <= '0;
            r_sub       <= 2'd0;
            r_esc       <= ESC_NONE;
            r_len       <= '0;
            r_cur       <= '0;
            r_enter     <= ENTER_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_unit  <= n_unit;
            r_idx   <= n_idx;
            r_end   <= n_end;
            r_rep   <= n_rep;
            r_sub   <= n_sub;
            if (w_accept) begin
                r_esc <= d_esc;
                r_len <= d_len;
                r_cur <= d_cur;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_enter <= i_cfg_data;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the output register, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_byte    <= e_byte;
            r_out_to_line <= e_to_line;
            r_out_done    <= e_done;
            r_out_last    <= e_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_to_line   = r_out_to_line;
    assign o_line_done = r_out_done;
    assign o_last      = r_out_last;

endmodule

[hw/rtl/tle_cell.sv]
// One character slot of the line store.
// Depends on tle_pkg; takes its left or right neighbour on insert / delete.
module tle_cell (
    input  logic                      i_clk,
    input  logic [tle_pkg::IDX_W-1:0]  i_index,
    input  tle_pkg::t_cell_cmd        i_cmd,
    input  logic [tle_pkg::BYTE_W-1:0] i_left,
    input  logic [tle_pkg::BYTE_W-1:0] i_right,
    output logic [tle_pkg::BYTE_W-1:0] o_data
);
    import tle_pkg::*;

    logic [BYTE_W-1:0] r_data;
    logic [BYTE_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (i_index == i_cmd.pos) begin
                    n_data = i_cmd.data;
                end else if (i_index > i_cmd.pos) begin
                    n_data = i_left;
                end
            end
            CELL_DELETE: begin
                if (i_index >= i_cmd.pos) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[hw/rtl/tle_cell_row.sv]
// Row of tle_cell slots forming the line store, with one read port.
// Depends on tle_pkg and tle_cell.
module tle_cell_row (
    input  logic                       i_clk,
    input  tle_pkg::t_cell_cmd         i_cmd,
    input  logic [tle_pkg::IDX_W-1:0]  i_rd_idx,
    output logic [tle_pkg::BYTE_W-1:0] o_rd_data
);
    import tle_pkg::*;

    logic [BYTE_W-1:0] w_data  [LINE_CAPACITY];
    logic [BYTE_W-1:0] w_left  [LINE_CAPACITY];
    logic [BYTE_W-1:0] w_right [LINE_CAPACITY];

    for (genvar g = 0; g < LINE_CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_mid_l
            assign w_left[g] = w_data[g-1];
        end
        if (g == LINE_CAPACITY - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_mid_r
            assign w_right[g] = w_data[g+1];
        end

        tle_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_cmd   (i_cmd),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_data  (w_data[g])
        );
    end

    assign o_rd_data = w_data[i_rd_idx];

endmodule
